[hw/rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and default sizes of the buffer cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  // default sizes
  localparam int SLOTS_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;
  localparam int REF_BITS_DEF = 8;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 16;
  localparam int SIDX_W   = 4;
  localparam int LIMIT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int RSLOT_W  = 4;
  localparam int FREED_W  = 5;
  localparam int BCOUNT_W = 17;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 17'h10000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_PUT     = 2'd1,
    ACT_MARK    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_NOSLOT = 2'd2,
    STAT_UNREF  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SRCH, S_VICT_L, S_VICT_S, S_SLOT,
    S_MV_B, S_MV_C, S_MV_D, S_MV_E, S_MV_F, S_MV_G,
    S_REL_H, S_REL, S_DONE
  } state_t;

  // one result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RSLOT_W-1:0]  result_slot;
    logic                hit;
    logic                data_valid;
    logic                needs_page;
    logic [FREED_W-1:0]  freed_count;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/bbc_in_if.sv]
// ----------------------------------------------------------------------------
// bbc_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bbc_pkg::ACTION_W-1:0] action;
  logic [bbc_pkg::BLOCK_W-1:0]  block_id;
  logic [bbc_pkg::SIDX_W-1:0]   slot_index;
  logic [bbc_pkg::LIMIT_W-1:0]  free_limit;

  modport source (output valid, action, block_id, slot_index, free_limit, input ready);
  modport sink   (input valid, action, block_id, slot_index, free_limit, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbc_out_if.sv]
// ----------------------------------------------------------------------------
// bbc_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bbc_pkg::STATUS_W-1:0] status;
  logic [bbc_pkg::RSLOT_W-1:0]  result_slot;
  logic                         hit;
  logic                         data_valid;
  logic                         needs_page;
  logic [bbc_pkg::FREED_W-1:0]  freed_count;

  modport source (output valid, status, result_slot, hit, data_valid, needs_page,
                  freed_count, input ready);
  modport sink   (input valid, status, result_slot, hit, data_valid, needs_page,
                  freed_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbc_ctrl.sv]
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer over the slot memory and the link memory: tag scan, victim pick,
// list moves, release walk and the init pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ctrl #(
  parameter int SLOTS    = bbc_pkg::SLOTS_DEF,
  parameter int TAG_BITS = bbc_pkg::TAG_BITS_DEF,
  parameter int REF_BITS = bbc_pkg::REF_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bbc_pkg::BCOUNT_W-1:0]  block_count,
  bbc_in_if.sink                             in_ch,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output bbc_pkg::result_t                   res
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 2);
  localparam logic [LW-1:0] ACT_HEAD   = LW'(SLOTS);
  localparam logic [LW-1:0] INACT_HEAD = LW'(SLOTS + 1);
  localparam logic [LW-1:0] LAST_SLOT  = LW'(SLOTS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                used;
    logic                valid;
    logic                page;
    logic                act;
    logic [REF_BITS-1:0] refc;
  } slot_ent_t;

  typedef struct packed {
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } link_ent_t;

  // memories
  slot_ent_t slot_mem [SLOTS];
  link_ent_t link_mem [SLOTS+2];

  slot_ent_t srd_r, swd;
  link_ent_t lrd_r, lwd;
  logic          sre, swe, lre, lwe_n, lwe_p;
  logic [SW-1:0] sra, swa;
  logic [LW-1:0] lra, lwa;

  always_ff @(posedge clk) begin
    if (swe) slot_mem[swa] <= swd;
    if (sre) srd_r <= slot_mem[sra];
  end

  always_ff @(posedge clk) begin
    if (lwe_n) link_mem[lwa].nxt <= lwd.nxt;
    if (lwe_p) link_mem[lwa].prv <= lwd.prv;
    if (lre) lrd_r <= link_mem[lra];
  end

  // control and request registers
  bbc_pkg::state_t state_r, state_nxt;
  logic [LW-1:0] init_r, init_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [LW-1:0] node_r, node_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] p_r, p_nxt, x_r, x_nxt, hn_r, hn_nxt;
  bbc_pkg::action_t act_r, act_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [bbc_pkg::SIDX_W-1:0]  sidx_r, sidx_nxt;
  logic [bbc_pkg::LIMIT_W-1:0] lim_r, lim_nxt;
  bbc_pkg::result_t res_r, res_nxt;

  // shared conditions
  logic acc, range_bad, sidx_bad, init_last, match, scan_last;
  logic vict_bad, rel_free, rel_cont;
  logic [bbc_pkg::FREED_W-1:0] cnt_inc;

  assign in_ch.ready = (state_r == bbc_pkg::S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign range_bad   = {1'b0, in_ch.block_id} >= block_count;
  assign sidx_bad    = 32'(in_ch.slot_index) >= SLOTS;
  assign init_last   = (init_r == INACT_HEAD);
  assign match       = srd_r.used && (srd_r.tag == tag_r);
  assign scan_last   = (scan_r == SW'(SLOTS - 1));
  assign vict_bad    = (lrd_r.prv >= ACT_HEAD);
  assign rel_free    = (srd_r.refc == '0) && srd_r.page;
  assign cnt_inc     = res_r.freed_count + bbc_pkg::FREED_W'(rel_free);
  assign rel_cont    = (lrd_r.prv < ACT_HEAD) && (cnt_inc < lim_r);

  assign res_valid = (state_r == bbc_pkg::S_DONE);
  assign res       = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbc_pkg::S_INIT: if (init_last) state_nxt = bbc_pkg::S_IDLE;
      bbc_pkg::S_IDLE: begin
        if (acc) begin
          unique case (bbc_pkg::action_t'(in_ch.action))
            bbc_pkg::ACT_GET:     state_nxt = range_bad ? bbc_pkg::S_DONE : bbc_pkg::S_SRCH;
            bbc_pkg::ACT_PUT,
            bbc_pkg::ACT_MARK:    state_nxt = sidx_bad ? bbc_pkg::S_DONE : bbc_pkg::S_SLOT;
            bbc_pkg::ACT_RELEASE: state_nxt = bbc_pkg::S_REL_H;
          endcase
        end
      end
      bbc_pkg::S_SRCH: begin
        if (match) state_nxt = bbc_pkg::S_MV_B;
        else if (scan_last) state_nxt = bbc_pkg::S_VICT_L;
      end
      bbc_pkg::S_VICT_L: state_nxt = vict_bad ? bbc_pkg::S_DONE : bbc_pkg::S_VICT_S;
      bbc_pkg::S_VICT_S: state_nxt = (srd_r.refc != '0) ? bbc_pkg::S_DONE : bbc_pkg::S_MV_B;
      bbc_pkg::S_SLOT: begin
        if (act_r == bbc_pkg::ACT_PUT && srd_r.refc == REF_BITS'(1)) state_nxt = bbc_pkg::S_MV_B;
        else state_nxt = bbc_pkg::S_DONE;
      end
      bbc_pkg::S_MV_B: state_nxt = bbc_pkg::S_MV_C;
      bbc_pkg::S_MV_C: state_nxt = bbc_pkg::S_MV_D;
      bbc_pkg::S_MV_D: state_nxt = bbc_pkg::S_MV_E;
      bbc_pkg::S_MV_E: state_nxt = bbc_pkg::S_MV_F;
      bbc_pkg::S_MV_F: state_nxt = bbc_pkg::S_MV_G;
      bbc_pkg::S_MV_G: state_nxt = bbc_pkg::S_DONE;
      bbc_pkg::S_REL_H: begin
        state_nxt = (lrd_r.prv < ACT_HEAD && lim_r != '0) ? bbc_pkg::S_REL : bbc_pkg::S_DONE;
      end
      bbc_pkg::S_REL:  state_nxt = rel_cont ? bbc_pkg::S_REL : bbc_pkg::S_DONE;
      bbc_pkg::S_DONE: if (res_ready) state_nxt = bbc_pkg::S_IDLE;
      default: state_nxt = bbc_pkg::S_IDLE;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    sre = 1'b0; sra = '0; swe = 1'b0; swa = '0; swd = srd_r;
    lre = 1'b0; lra = '0; lwe_n = 1'b0; lwe_p = 1'b0; lwa = '0; lwd = lrd_r;
    init_nxt = init_r; scan_nxt = scan_r; node_nxt = node_r; head_nxt = head_r;
    p_nxt = p_r; x_nxt = x_r; hn_nxt = hn_r;
    act_nxt = act_r; tag_nxt = tag_r; sidx_nxt = sidx_r; lim_nxt = lim_r;
    res_nxt = res_r;
    unique case (state_r)
      // write reset contents, one entry a cycle
      bbc_pkg::S_INIT: begin
        init_nxt = init_r + LW'(1);
        lwe_n = 1'b1; lwe_p = 1'b1; lwa = init_r;
        if (init_r == ACT_HEAD) begin
          lwd.nxt = ACT_HEAD; lwd.prv = ACT_HEAD;
        end else if (init_r == INACT_HEAD) begin
          lwd.nxt = '0; lwd.prv = LAST_SLOT;
        end else begin
          lwd.nxt = (init_r == LAST_SLOT) ? INACT_HEAD : init_r + LW'(1);
          lwd.prv = (init_r == '0) ? INACT_HEAD : init_r - LW'(1);
          swe = 1'b1; swa = SW'(init_r); swd = '0;
        end
      end
      bbc_pkg::S_IDLE: begin
        if (acc) begin
          act_nxt  = bbc_pkg::action_t'(in_ch.action);
          tag_nxt  = TAG_BITS'(in_ch.block_id);
          sidx_nxt = in_ch.slot_index;
          lim_nxt  = in_ch.free_limit;
          res_nxt  = '0;
          scan_nxt = '0;
          node_nxt = LW'(in_ch.slot_index);
          unique case (bbc_pkg::action_t'(in_ch.action))
            bbc_pkg::ACT_GET: begin
              if (range_bad) res_nxt.status = bbc_pkg::STAT_RANGE;
              else begin
                sre = 1'b1; sra = '0;
              end
            end
            bbc_pkg::ACT_PUT: begin
              if (sidx_bad) res_nxt.status = bbc_pkg::STAT_UNREF;
              else begin
                sre = 1'b1; sra = SW'(in_ch.slot_index);
              end
            end
            bbc_pkg::ACT_MARK: begin
              if (!sidx_bad) begin
                sre = 1'b1; sra = SW'(in_ch.slot_index);
              end
            end
            bbc_pkg::ACT_RELEASE: begin
              lre = 1'b1; lra = INACT_HEAD;
            end
          endcase
        end
      end
      // tag scan, one slot a cycle
      bbc_pkg::S_SRCH: begin
        if (match) begin
          node_nxt = LW'(scan_r);
          head_nxt = ACT_HEAD;
          res_nxt.hit = 1'b1;
          res_nxt.result_slot = bbc_pkg::RSLOT_W'(scan_r);
          res_nxt.data_valid = srd_r.valid;
          swe = 1'b1; swa = scan_r;
          swd.act = 1'b1;
          if (srd_r.refc != REF_MAX) swd.refc = srd_r.refc + REF_BITS'(1);
          lre = 1'b1; lra = LW'(scan_r);
        end else if (scan_last) begin
          lre = 1'b1; lra = INACT_HEAD;
        end else begin
          scan_nxt = scan_r + SW'(1);
          sre = 1'b1; sra = scan_r + SW'(1);
        end
      end
      bbc_pkg::S_VICT_L: begin
        node_nxt = lrd_r.prv;
        if (vict_bad) res_nxt.status = bbc_pkg::STAT_NOSLOT;
        else begin
          sre = 1'b1; sra = SW'(lrd_r.prv);
        end
      end
      bbc_pkg::S_VICT_S: begin
        if (srd_r.refc != '0) res_nxt.status = bbc_pkg::STAT_NOSLOT;
        else begin
          res_nxt.needs_page = !srd_r.page;
          res_nxt.result_slot = bbc_pkg::RSLOT_W'(node_r);
          head_nxt = ACT_HEAD;
          swe = 1'b1; swa = SW'(node_r);
          swd.tag = tag_r; swd.used = 1'b1; swd.valid = 1'b0; swd.page = 1'b1;
          swd.act = 1'b1; swd.refc = REF_BITS'(1);
          lre = 1'b1; lra = node_r;
        end
      end
      // put or mark valid on the read slot
      bbc_pkg::S_SLOT: begin
        swa = SW'(sidx_r);
        if (act_r == bbc_pkg::ACT_MARK) begin
          swe = 1'b1; swd.valid = 1'b1;
        end else if (srd_r.refc == '0) begin
          res_nxt.status = bbc_pkg::STAT_UNREF;
        end else begin
          swe = 1'b1; swd.refc = srd_r.refc - REF_BITS'(1);
          head_nxt = INACT_HEAD;
          if (srd_r.refc == REF_BITS'(1)) begin
            swd.act = 1'b0;
            lre = 1'b1; lra = LW'(sidx_r);
          end
        end
      end
      // list move: unlink, then insert after the head
      bbc_pkg::S_MV_B: begin
        p_nxt = lrd_r.prv; x_nxt = lrd_r.nxt;
        lwe_n = 1'b1; lwa = lrd_r.prv; lwd.nxt = lrd_r.nxt;
      end
      bbc_pkg::S_MV_C: begin
        lwe_p = 1'b1; lwa = x_r; lwd.prv = p_r;
      end
      bbc_pkg::S_MV_D: begin
        lre = 1'b1; lra = head_r;
      end
      bbc_pkg::S_MV_E: begin
        hn_nxt = lrd_r.nxt;
        lwe_n = 1'b1; lwe_p = 1'b1; lwa = node_r;
        lwd.nxt = lrd_r.nxt; lwd.prv = head_r;
      end
      bbc_pkg::S_MV_F: begin
        lwe_p = 1'b1; lwa = hn_r; lwd.prv = node_r;
      end
      bbc_pkg::S_MV_G: begin
        lwe_n = 1'b1; lwa = head_r; lwd.nxt = node_r;
      end
      // release walk from the inactive tail
      bbc_pkg::S_REL_H: begin
        node_nxt = lrd_r.prv;
        if (lrd_r.prv < ACT_HEAD && lim_r != '0) begin
          sre = 1'b1; sra = SW'(lrd_r.prv);
          lre = 1'b1; lra = lrd_r.prv;
        end
      end
      bbc_pkg::S_REL: begin
        res_nxt.freed_count = cnt_inc;
        if (rel_free) begin
          swe = 1'b1; swa = SW'(node_r);
          swd.tag = '0; swd.used = 1'b0; swd.valid = 1'b0; swd.page = 1'b0;
        end
        node_nxt = lrd_r.prv;
        if (rel_cont) begin
          sre = 1'b1; sra = SW'(lrd_r.prv);
          lre = 1'b1; lra = lrd_r.prv;
        end
      end
      bbc_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbc_pkg::S_INIT;
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt; node_r <= node_nxt; head_r <= head_nxt;
    p_r <= p_nxt; x_r <= x_nxt; hn_r <= hn_nxt;
    act_r <= act_nxt; tag_r <= tag_nxt; sidx_r <= sidx_nxt; lim_r <= lim_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/bbc_out_reg.sv]
// ----------------------------------------------------------------------------
// bbc_out_reg
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire bbc_pkg::result_t  push_data,
  bbc_out_if.source              out_ch
);

  logic             full_r, full_nxt;
  bbc_pkg::result_t data_r, data_nxt;

  assign push_ready = !full_r || out_ch.ready;

  // hold until taken, reload on push
  always_comb begin
    full_nxt = full_r;
    data_nxt = data_r;
    if (out_ch.valid && out_ch.ready) full_nxt = 1'b0;
    if (push_valid && push_ready) begin
      full_nxt = 1'b1;
      data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else full_r <= full_nxt;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid       = full_r;
  assign out_ch.status      = data_r.status;
  assign out_ch.result_slot = data_r.result_slot;
  assign out_ch.hit         = data_r.hit;
  assign out_ch.data_valid  = data_r.data_valid;
  assign out_ch.needs_page  = data_r.needs_page;
  assign out_ch.freed_count = data_r.freed_count;

endmodule

`default_nettype wire

[hw/rtl/block_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Buffer cache directory with active/inactive LRU lists held in memories.
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time; the tag scan and the list walk read
//   the slot and link memories one entry per cycle.
// Reset: synchronous; an init pass writes every entry of both memories
//   while in_ch.ready stays low; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lru #(
  parameter int SLOTS    = bbc_pkg::SLOTS_DEF,
  parameter int TAG_BITS = bbc_pkg::TAG_BITS_DEF,
  parameter int REF_BITS = bbc_pkg::REF_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bbc_pkg::BCOUNT_W-1:0] cfg_block_count,
  bbc_in_if.sink                            in_ch,
  bbc_out_if.source                         out_ch
);

  logic [bbc_pkg::BCOUNT_W-1:0] bcount_r;
  logic             res_valid, res_ready;
  bbc_pkg::result_t res;

  // block count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) bcount_r <= bbc_pkg::BCOUNT_RST;
    else if (cfg_valid) bcount_r <= cfg_block_count;
  end

  bbc_ctrl #(
    .SLOTS(SLOTS), .TAG_BITS(TAG_BITS), .REF_BITS(REF_BITS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .block_count(bcount_r), .in_ch(in_ch),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  bbc_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push_valid(res_valid), .push_ready(res_ready),
    .push_data(res), .out_ch(out_ch)
  );

endmodule

`default_nettype wire
